// File: design/ipipb_pkg.sv
// Package for the IP-in-IP packet builder.
// Holds the payload structs, header constants and the header word type.
// No dependencies.
`default_nettype none
package ipipb_pkg;

    localparam int PKT_WORDS   = 11;
    localparam int HDR_WORDS   = 5;
    localparam int IDX_W       = 4;

    localparam logic [7:0]  HDR_VER_IHL   = 8'h45;
    localparam logic [15:0] HDR_DF        = 16'h4000;
    localparam logic [7:0]  INNER_TTL     = 8'd64;
    localparam logic [7:0]  OUTER_TTL     = 8'd128;
    localparam logic [7:0]  PROTO_TUNNEL  = 8'd4;
    localparam logic [7:0]  PROTO_NUM_UDP = 8'd17;
    localparam logic [7:0]  PROTO_NUM_TCP = 8'd6;
    localparam logic [15:0] OUTER_LEN     = 16'd44;
    localparam logic [15:0] INNER_BYTES   = 16'd24;
    localparam logic [15:0] IDENT_RESET   = 16'd1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PKT_WORDS - 1);

    // Configuration register indexes.
    localparam logic CFG_LOCAL_ADDR  = 1'b0;
    localparam logic CFG_REMOTE_ADDR = 1'b1;

    typedef struct packed {
        logic [31:0] client_addr;
        logic [31:0] server_addr;
        logic [15:0] client_port_num;
        logic [15:0] server_port_num;
        logic        is_udp;
    } conn_rec_t;

    typedef struct packed {
        logic [31:0]      pkt_word;
        logic [IDX_W-1:0] word_index;
        logic             last_word;
    } pkt_out_t;

    typedef logic [HDR_WORDS-1:0][31:0] hdr_words_t;

endpackage
`default_nettype wire

// File: design/ipipb_hdr_gen.sv
// Builds the five words of one IPv4 header, checksum included.
// Depends on ipipb_pkg.
`default_nettype none
module ipipb_hdr_gen
    import ipipb_pkg::*;
(
    input  wire logic [31:0] src,
    input  wire logic [31:0] dst,
    input  wire logic [7:0]  proto,
    input  wire logic [7:0]  ttl,
    input  wire logic [15:0] len_field,
    input  wire logic [15:0] ident,
    output hdr_words_t       words
);

    logic [19:0] sum_raw;
    logic [16:0] sum_fold1;
    logic [15:0] sum_fold2;

    // The checksum field counts as zero; the sum of the other nine halfwords fits in 20 bits.
    assign sum_raw = 20'({HDR_VER_IHL, 8'h00}) + 20'(len_field) + 20'(ident) +
                     20'(HDR_DF) + 20'({ttl, proto}) +
                     20'(src[31:16]) + 20'(src[15:0]) +
                     20'(dst[31:16]) + 20'(dst[15:0]);

    // Two end-around folds are enough for a 20-bit sum.
    assign sum_fold1 = 17'(sum_raw[15:0]) + 17'(sum_raw[19:16]);
    assign sum_fold2 = sum_fold1[15:0] + 16'(sum_fold1[16]);

    always_comb
    begin
        words[0] = {HDR_VER_IHL, 8'h00, len_field};
        words[1] = {ident, HDR_DF};
        words[2] = {ttl, proto, ~sum_fold2};
        words[3] = src;
        words[4] = dst;
    end

endmodule
`default_nettype wire

// File: design/ipip_packet_builder_top.sv
// Top level of the IP-in-IP packet builder.
// Depends on ipipb_pkg and ipipb_hdr_gen.
//
// One accepted connection record produces a 44-byte IP-in-IP packet as eleven
// 32-bit result items, word 0 first, the earliest packet byte in bits 31:24.
// The record waits in an input register; when the packet register is empty or
// its last word is being taken, both headers and their checksums are built
// combinationally from that record, the tunnel addresses and the identification
// counter, and loaded into the packet register. The output side then hands
// out one word per cycle while out_stall is low; the single output word port
// sets the rate of a steady stream. A new record is taken while the current
// packet still drains, and packets follow each other with no gap. The inner
// header takes identification N and the outer header N+1; the counter starts
// at 1 after reset and steps by two per packet, wrapping modulo 65536. The
// tunnel addresses come from two registers written through the configuration
// port (index 0 local, index 1 remote) and must only change while idle.
`default_nettype none
module ipip_packet_builder_top
    import ipipb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire conn_rec_t   in_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output pkt_out_t         out_data
);

    logic [31:0] local_addr_reg;
    logic [31:0] remote_addr_reg;
    logic [15:0] ident_reg;
    logic [15:0] ident_next;

    conn_rec_t   rec_reg;
    logic        rec_valid_reg;
    logic        rec_valid_next;

    logic [PKT_WORDS-1:0][31:0] words_reg;
    logic        pkt_valid_reg;
    logic        pkt_valid_next;
    logic [IDX_W-1:0] cnt_reg;
    logic [IDX_W-1:0] cnt_next;

    logic        out_fire;
    logic        out_last;
    logic        load_pkt;
    hdr_words_t  outer_words;
    hdr_words_t  inner_words;
    logic [7:0]  conn_proto;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_addr_reg  <= '0;
            remote_addr_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_LOCAL_ADDR:  local_addr_reg  <= cfg_data;
                CFG_REMOTE_ADDR: remote_addr_reg <= cfg_data;
                default:         local_addr_reg  <= local_addr_reg;
            endcase
        end
    end

    // Handshake and flow between the record register and the packet register.
    assign out_valid = pkt_valid_reg;
    assign out_fire  = pkt_valid_reg && !out_stall;
    assign out_last  = (cnt_reg == LAST_IDX);
    assign load_pkt  = rec_valid_reg && (!pkt_valid_reg || (out_fire && out_last));
    assign in_stall  = rec_valid_reg && !load_pkt;

    always_comb
    begin
        rec_valid_next = rec_valid_reg;
        if (in_valid && !in_stall)
        begin
            rec_valid_next = 1'b1;
        end
        else if (load_pkt)
        begin
            rec_valid_next = 1'b0;
        end

        pkt_valid_next = pkt_valid_reg;
        cnt_next       = cnt_reg;
        if (out_fire)
        begin
            if (out_last)
            begin
                cnt_next       = '0;
                pkt_valid_next = load_pkt;
            end
            else
            begin
                cnt_next = cnt_reg + IDX_W'(1);
            end
        end
        else if (load_pkt)
        begin
            pkt_valid_next = 1'b1;
            cnt_next       = '0;
        end

        ident_next = load_pkt ? ident_reg + 16'd2 : ident_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_valid_reg <= 1'b0;
            pkt_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            ident_reg     <= IDENT_RESET;
        end
        else
        begin
            rec_valid_reg <= rec_valid_next;
            pkt_valid_reg <= pkt_valid_next;
            cnt_reg       <= cnt_next;
            ident_reg     <= ident_next;
        end
    end

    // Header generation from the waiting record.
    assign conn_proto = rec_reg.is_udp ? PROTO_NUM_UDP : PROTO_NUM_TCP;

    ipipb_hdr_gen u_tunnel_hdr (
        .src       (local_addr_reg),
        .dst       (remote_addr_reg),
        .proto     (PROTO_TUNNEL),
        .ttl       (OUTER_TTL),
        .len_field (OUTER_LEN),
        .ident     (ident_reg + 16'd1),
        .words     (outer_words)
    );

    ipipb_hdr_gen u_conn_hdr (
        .src       (rec_reg.client_addr),
        .dst       (rec_reg.server_addr),
        .proto     (conn_proto),
        .ttl       (INNER_TTL),
        .len_field (INNER_BYTES),
        .ident     (ident_reg),
        .words     (inner_words)
    );

    // Payload registers: the record and the finished packet.
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            rec_reg <= in_data;
        end
        if (load_pkt)
        begin
            for (int i = 0; i < HDR_WORDS; i++)
            begin
                words_reg[i]             <= outer_words[i];
                words_reg[i + HDR_WORDS] <= inner_words[i];
            end
            words_reg[PKT_WORDS-1] <= {rec_reg.client_port_num, rec_reg.server_port_num};
        end
    end

    always_comb
    begin
        out_data.pkt_word   = words_reg[cnt_reg];
        out_data.word_index = cnt_reg;
        out_data.last_word  = out_last;
    end

`ifndef SYNTH
    // The word counter never runs past the last word of a packet.
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= LAST_IDX)
        else $error("word counter out of range");

    // The counter starts odd and steps by two, so it always stays odd.
    a_ident_odd: assert property (@(posedge clk) disable iff (!rst_n)
        ident_reg[0] == 1'b1)
        else $error("identification counter lost its odd phase");

    // Taking the last word with no record waiting leaves the output empty.
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && out_last && !rec_valid_reg) |=> !out_valid)
        else $error("output stayed valid after the last word");

    // A new packet always starts at word zero.
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        load_pkt |=> (cnt_reg == '0) && out_valid)
        else $error("new packet did not start at word zero");
`endif

endmodule
`default_nettype wire
